[design/mcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcr_pkg
// Register offsets, reply codes and command decode for the mailbox command
// responder.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int MSG_DEPTH_DEF = 16;
	localparam int TX_SLOTS_DEF  = 8;
	localparam int RX_SLOTS_DEF  = 4;

	localparam logic [9:0] OFS_PAR     = 10'h004;
	localparam logic [9:0] OFS_GIER    = 10'h110;
	localparam logic [9:0] OFS_GCR     = 10'h114;
	localparam logic [9:0] OFS_TCR     = 10'h120;
	localparam logic [9:0] OFS_TSR     = 10'h124;
	localparam logic [9:0] OFS_RCR     = 10'h128;
	localparam logic [9:0] OFS_RSR     = 10'h12C;
	localparam logic [9:0] OFS_TX_BASE = 10'h200;
	localparam logic [9:0] OFS_RX_BASE = 10'h280;

	localparam logic [7:0] REPLY_TAG   = 8'he1;
	localparam logic [7:0] STATUS_OK   = 8'hd6;
	localparam logic [7:0] STATUS_FAIL = 8'h29;

	localparam logic [7:0] CMD_PING     = 8'h01;
	localparam logic [7:0] CMD_A        = 8'h12;
	localparam logic [7:0] CMD_B        = 8'h13;
	localparam logic [7:0] CMD_C        = 8'ha3;
	localparam logic [7:0] CMD_D        = 8'hdf;
	localparam logic [7:0] CMD_E        = 8'hda;
	localparam logic [7:0] CMD_FOUR_A   = 8'hb2;
	localparam logic [7:0] CMD_FOUR_B   = 8'h9d;
	localparam logic [7:0] CMD_THREE    = 8'h97;
	localparam logic [7:0] CMD_RANDOM   = 8'hcd;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	function automatic logic on_list(input logic [7:0] cmd);
		logic hit;
		hit = (cmd == CMD_PING) || (cmd == CMD_A) || (cmd == CMD_B) ||
			(cmd == CMD_C) || (cmd == CMD_D) || (cmd == CMD_E) ||
			(cmd == CMD_FOUR_A) || (cmd == CMD_FOUR_B) || (cmd == CMD_THREE);
		return hit;
	endfunction

	function automatic logic [2:0] success_words(input logic [7:0] cmd);
		logic [2:0] n;
		if (cmd == CMD_THREE) begin
			n = 3'd3;
		end else if (cmd == CMD_FOUR_A || cmd == CMD_FOUR_B) begin
			n = 3'd4;
		end else begin
			n = 3'd2;
		end
		return n;
	endfunction

endpackage
`default_nettype wire

[design/mailbox_command_responder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mailbox_command_responder
// Register-bus mailbox: collects transmit words into a message, answers each
// complete message with a reply in the receive words, keeps control registers.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  in       | in_valid, in_stall, action, offset,       | bus access in
//           | write_data                                |
//  out      | out_valid, out_stall, read_data,          | access result out
//           | irq_transmit, irq_receive, bad_access     |
//  cfg      | cfg_we, fake_success                      | register write in
//
// one access per cycle unless out stalls; via input and result registers
// all state but fake_q changes when an access moves from input to result register
// reset clears valid flags, control registers, reply words and the message counter
// a stall on out holds the result register and, once the input register is
// also full, raises in_stall
// ----------------------------------------------------------------------------
module mailbox_command_responder #(
	parameter int MSG_DEPTH = mcr_pkg::MSG_DEPTH_DEF,
	parameter int TX_SLOTS  = mcr_pkg::TX_SLOTS_DEF,
	parameter int RX_SLOTS  = mcr_pkg::RX_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        fake_success,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [9:0]  offset,
	input  wire logic [31:0] write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      read_data,
	output logic             irq_transmit,
	output logic             irq_receive,
	output logic             bad_access
);

	localparam int CW  = $clog2(MSG_DEPTH + 1);
	localparam int RXW = $clog2(RX_SLOTS);
	localparam logic [9:0] TX_LAST = 10'(32'(mcr_pkg::OFS_TX_BASE) + (TX_SLOTS - 1) * 4);
	localparam logic [9:0] RX_LAST = 10'(32'(mcr_pkg::OFS_RX_BASE) + (RX_SLOTS - 1) * 4);
	localparam logic [31:0] PAR_VAL = {16'h0, 8'(RX_SLOTS), 8'(TX_SLOTS)};
	localparam logic [31:0] TSR_VAL = 32'((64'd1 << TX_SLOTS) - 64'd1);
	localparam logic [7:0] DEPTH8 = 8'(MSG_DEPTH);

	// configuration
	logic fake_q;

	// input register
	logic        valid_s1;
	logic        action_s1;
	logic [9:0]  offset_s1;
	logic [31:0] data_s1;

	// result register
	logic        valid_s2;
	logic [31:0] rdata_s2;
	logic        irq_tx_s2;
	logic        irq_rx_s2;
	logic        bad_s2;

	// block state
	logic [31:0]   gier_q, gcr_q, tcr_q, rcr_q;
	logic [7:0]    ver_q, cmd_q;
	logic [CW-1:0] count_q, len_q;
	logic [31:0]   reply_q [4];
	logic [3:0]    full_q;

	// next state
	logic [31:0]   gier_d, gcr_d, tcr_d, rcr_d;
	logic [7:0]    ver_d, cmd_d;
	logic [CW-1:0] count_d, len_d;
	logic [31:0]   reply_d [4];
	logic [3:0]    full_d;
	logic [31:0]   rdata_d;
	logic          bad_d;

	logic          adv;
	logic          tx_hit, rx_hit, first, done, ok;
	logic [9:0]    rx_off;
	logic [RXW-1:0] rx_idx;
	logic [7:0]    size8;
	logic [CW-1:0] len_new, len_use, count_inc;
	logic [2:0]    words;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign out_valid    = valid_s2;
	assign read_data    = rdata_s2;
	assign irq_transmit = irq_tx_s2;
	assign irq_receive  = irq_rx_s2;
	assign bad_access   = bad_s2;

	always_comb begin
		tx_hit    = (offset_s1 >= mcr_pkg::OFS_TX_BASE) && (offset_s1 <= TX_LAST);
		rx_hit    = (offset_s1 >= mcr_pkg::OFS_RX_BASE) && (offset_s1 <= RX_LAST);
		rx_off    = offset_s1 - mcr_pkg::OFS_RX_BASE;
		rx_idx    = rx_off[RXW+1:2];
		first     = (count_q == '0);
		size8     = data_s1[15:8];
		if (size8 == 8'd0) begin
			len_new = CW'(1);
		end else if (size8 > DEPTH8) begin
			len_new = CW'(MSG_DEPTH);
		end else begin
			len_new = CW'(size8);
		end
		len_use   = first ? len_new : len_q;
		count_inc = count_q + CW'(1);
		done      = (count_inc >= len_use);

		gier_d  = gier_q;
		gcr_d   = gcr_q;
		tcr_d   = tcr_q;
		rcr_d   = rcr_q;
		ver_d   = ver_q;
		cmd_d   = cmd_q;
		count_d = count_q;
		len_d   = len_q;
		reply_d = reply_q;
		full_d  = full_q;
		rdata_d = '0;
		bad_d   = 1'b0;

		if (first) begin
			ver_d = data_s1[7:0];
			cmd_d = data_s1[23:16];
		end
		ok    = fake_q || mcr_pkg::on_list(cmd_d) || (cmd_d == mcr_pkg::CMD_RANDOM);
		words = ok ? mcr_pkg::success_words(cmd_d) : 3'd2;

		if (action_s1 == mcr_pkg::ACT_WRITE) begin
			if (tx_hit) begin
				len_d = len_use;
				if (!first) begin
					ver_d = ver_q;
					cmd_d = cmd_q;
				end
				if (done) begin
					count_d    = '0;
					reply_d[0] = {mcr_pkg::REPLY_TAG, cmd_d, 5'd0, words, ver_d};
					reply_d[1] = {24'd0, ok ? mcr_pkg::STATUS_OK : mcr_pkg::STATUS_FAIL};
					if (words >= 3'd3) begin
						reply_d[2] = '0;
					end
					if (words == 3'd4) begin
						reply_d[3] = '0;
					end
					unique case (words)
						3'd3:    full_d = 4'b0111;
						3'd4:    full_d = 4'b1111;
						default: full_d = 4'b0011;
					endcase
				end else begin
					count_d = count_inc;
				end
			end else if (offset_s1 == mcr_pkg::OFS_GIER) begin
				gier_d = data_s1;
			end else if (offset_s1 == mcr_pkg::OFS_GCR) begin
				gcr_d = data_s1;
			end else if (offset_s1 == mcr_pkg::OFS_TCR) begin
				tcr_d = data_s1;
			end else if (offset_s1 == mcr_pkg::OFS_RCR) begin
				rcr_d = data_s1;
			end else begin
				bad_d = 1'b1;
			end
		end else begin
			ver_d = ver_q;
			cmd_d = cmd_q;
			if (offset_s1 == mcr_pkg::OFS_PAR) begin
				rdata_d = PAR_VAL;
			end else if (offset_s1 == mcr_pkg::OFS_TSR) begin
				rdata_d = TSR_VAL;
			end else if (offset_s1 == mcr_pkg::OFS_RSR) begin
				rdata_d = {28'd0, full_q};
			end else if (offset_s1 == mcr_pkg::OFS_GIER) begin
				rdata_d = gier_q;
			end else if (offset_s1 == mcr_pkg::OFS_GCR) begin
				rdata_d = gcr_q;
			end else if (offset_s1 == mcr_pkg::OFS_TCR) begin
				rdata_d = tcr_q;
			end else if (offset_s1 == mcr_pkg::OFS_RCR) begin
				rdata_d = rcr_q;
			end else if (rx_hit) begin
				// receive words from index four up are never filled and read zero
				if (32'(rx_idx) < 4) begin
					rdata_d = reply_q[rx_idx[1:0]];
					full_d[rx_idx[1:0]] = 1'b0;
				end
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fake_q <= 1'b0;
		end else if (cfg_we) begin
			fake_q <= fake_success;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			action_s1 <= action;
			offset_s1 <= offset;
			data_s1   <= write_data;
		end
		if (adv) begin
			rdata_s2  <= rdata_d;
			irq_tx_s2 <= tcr_d[0];
			irq_rx_s2 <= full_d[0] & rcr_d[0];
			bad_s2    <= bad_d;
			ver_q     <= ver_d;
			cmd_q     <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gier_q  <= '0;
			gcr_q   <= '0;
			tcr_q   <= '0;
			rcr_q   <= '0;
			count_q <= '0;
			len_q   <= '0;
			full_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				reply_q[i] <= '0;
			end
		end else if (adv) begin
			gier_q  <= gier_d;
			gcr_q   <= gcr_d;
			tcr_q   <= tcr_d;
			rcr_q   <= rcr_d;
			count_q <= count_d;
			len_q   <= len_d;
			full_q  <= full_d;
			reply_q <= reply_d;
		end
	end

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || (count_q < len_q))
		else $error("message counter beyond message length");

	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(MSG_DEPTH))
		else $error("message length above buffer depth");

	a_adv_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("transfer into result register lost");

	a_irq_tx_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (irq_tx_s2 == tcr_q[0]))
		else $error("transmit interrupt out of step with control register");

	a_irq_rx_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (irq_rx_s2 == (full_q[0] & rcr_q[0])))
		else $error("receive interrupt out of step with full bits");

endmodule
`default_nettype wire
